@@ hw/rtl/vt100_pkg.sv @@
// ----------------------------------------------------------------------------
// VT100 engine package
// Shared types, codes and the color palette of the escape text engine.
// ----------------------------------------------------------------------------
package vt100_pkg;

    localparam logic [7:0] CH_ESC = 8'd27;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    localparam logic [1:0] PH_TEXT = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_SEQ  = 2'd2;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_FORE = 2'd2;
    localparam logic [1:0] REG_BACK = 2'd3;

    localparam logic CMD_DRAW  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic        command;
        logic [4:0]  cell_col;
        logic [4:0]  cell_row;
        logic [7:0]  glyph;
        logic [15:0] fore_colour;
        logic [15:0] back_colour;
        logic        last_of_run;
    } t_result;

    // Controller to datapath commands.
    typedef struct packed {
        logic        step;       // Process the byte held in the datapath.
        logic        load;       // Capture a new input byte.
        logic        run_next;   // Advance the erase run by one cell.
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic        has_result; // The step makes a first result.
        logic        run_more;   // An erase run has cells after this one.
    } t_dp_status;

    function automatic logic [15:0] palette(input logic [2:0] idx);
        case (idx)
            3'd0: palette = 16'h0000;
            3'd1: palette = 16'hF800;
            3'd2: palette = 16'h07E0;
            3'd3: palette = 16'hFFE0;
            3'd4: palette = 16'h001F;
            3'd5: palette = 16'hF81F;
            3'd6: palette = 16'h07FF;
            default: palette = 16'hFFFF;
        endcase
    endfunction

endpackage

@@ hw/rtl/vt100_stream_if.sv @@
// ----------------------------------------------------------------------------
// Stream interface
// Valid and ready handshake carrying one payload of parameter type.
// ----------------------------------------------------------------------------
interface vt100_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/vt100_ctrl.sv @@
// ----------------------------------------------------------------------------
// VT100 engine controller
// Sequences input capture, byte processing and erase-run emission.
// ----------------------------------------------------------------------------
module vt100_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  vt100_pkg::t_dp_status i_status,
    output vt100_pkg::t_dp_cmd    o_cmd
);
    import vt100_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       out_fire;

    assign out_fire    = (r_state == ST_OUT) && i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.step     = 1'b0;
        o_cmd.run_next = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.step = 1'b1;
                n_state    = i_status.has_result ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (out_fire) begin
                    if (i_status.run_more) begin
                        o_cmd.run_next = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

@@ hw/rtl/vt100_dp.sv @@
// ----------------------------------------------------------------------------
// VT100 engine datapath
// Parser state, cursor, colors and the result register with erase-run counter.
// ----------------------------------------------------------------------------
module vt100_dp #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32,
    parameter int PARAM_BUFFER_LEN = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_char_code,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    input  vt100_pkg::t_dp_cmd    i_cmd,
    output vt100_pkg::t_dp_status o_status,
    output vt100_pkg::t_result    o_result
);
    import vt100_pkg::*;

    localparam int ROW_CAP = (MAX_ROWS < 32) ? MAX_ROWS : 32;
    localparam int COL_CAP = (MAX_COLS < 32) ? MAX_COLS : 32;
    localparam int PCW = $clog2(PARAM_BUFFER_LEN + 1);

    logic [5:0]  r_max_rows, r_max_cols;
    logic [15:0] r_init_fore, r_init_back;
    logic [7:0]  r_char;
    logic [1:0]  r_phase;
    logic [PCW-1:0] r_pchars;
    logic [1:0]  r_pfield;
    logic [7:0]  r_p1, r_p2;
    logic        r_p1v, r_p2v;
    logic [4:0]  r_row, r_col, r_srow, r_scol;
    logic [15:0] r_fore, r_back;
    logic        r_wrap;
    t_result     r_res;
    logic [5:0]  r_run_end;

    logic [5:0] rows, cols;
    logic [5:0] cnt;
    logic [7:0] c;
    logic       is_digit;
    logic [3:0] dval;
    logic [5:0] row_dn1;
    logic [6:0] sum_r, sum_c;
    logic [5:0] k_st, k_en;
    logic [5:0] nxt_col;

    function automatic logic [7:0] mul_sat(input logic [7:0] p, input logic [3:0] d);
        logic [11:0] v;
        v = 12'(p) * 12'd10 + 12'(d);
        mul_sat = (v > 12'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic cnt_gt(input logic v, input logic [7:0] p, input logic [4:0] pos);
        cnt_gt = v ? (p > {3'b0, pos}) : (pos == 5'd0);
    endfunction

    always_comb begin
        rows = (r_max_rows == 6'd0) ? 6'd1 : r_max_rows;
        if (rows > 6'(ROW_CAP)) rows = 6'(ROW_CAP);
        cols = (r_max_cols == 6'd0) ? 6'd1 : r_max_cols;
        if (cols > 6'(COL_CAP)) cols = 6'(COL_CAP);
    end

    assign c        = r_char;
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign dval     = 4'(c - 8'h30);
    assign cnt      = r_p1v ? ((r_p1 > 8'd63) ? 6'd63 : r_p1[5:0]) : 6'd1;
    assign row_dn1  = ({1'b0, r_row} + 6'd1 >= rows) ? rows - 6'd1 : {1'b0, r_row} + 6'd1;
    assign sum_r    = {2'b0, r_row} + (r_p1v ? {r_p1 > 8'd63, r_p1[5:0]} : 7'd1);
    assign sum_c    = {2'b0, r_col} + (r_p1v ? {r_p1 > 8'd63, r_p1[5:0]} : 7'd1);
    assign nxt_col  = r_res.cell_col + 6'd1;

    always_comb begin
        if (r_p1v && r_p1 == 8'd1) begin
            k_st = 6'd0; k_en = {1'b0, r_col};
        end else if (r_p1v && r_p1 == 8'd2) begin
            k_st = 6'd0; k_en = cols;
        end else begin
            k_st = {1'b0, r_col}; k_en = cols;
        end
    end

    always_comb begin
        o_status.has_result = 1'b0;
        if (r_phase == PH_SEQ) begin
            if (!(is_digit || c == CH_SEMI)) begin
                if (c == "K") o_status.has_result = k_st < k_en;
                if (c == "J") o_status.has_result = r_p1v && r_p1 == 8'd2;
            end
        end else if (r_phase == PH_TEXT) begin
            o_status.has_result = !(c == CH_ESC || c == CH_CR || c == CH_LF || c == CH_BS);
        end
        o_status.run_more = !r_res.last_of_run;
    end

    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_char <= i_char_code;
        if (i_cmd.run_next) begin
            r_res.cell_col    <= nxt_col[4:0];
            r_res.last_of_run <= (nxt_col + 6'd1 >= r_run_end);
        end
        if (i_cmd.step) begin
            r_res.command     <= CMD_DRAW;
            r_res.cell_col    <= r_col;
            r_res.cell_row    <= r_row;
            r_res.glyph       <= c;
            r_res.fore_colour <= r_fore;
            r_res.back_colour <= r_back;
            r_res.last_of_run <= 1'b1;
            if (r_phase == PH_SEQ && c == "K") begin
                r_res.cell_col    <= k_st[4:0];
                r_res.glyph       <= 8'd0;
                r_res.last_of_run <= (k_st + 6'd1 >= k_en);
                r_run_end         <= k_en;
            end
            if (r_phase == PH_SEQ && c == "J") begin
                r_res.command     <= CMD_CLEAR;
                r_res.cell_col    <= 5'd0;
                r_res.cell_row    <= 5'd0;
                r_res.glyph       <= 8'd0;
                r_res.fore_colour <= 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rows  <= 6'd20;
            r_max_cols  <= 6'd21;
            r_init_fore <= 16'hFFFF;
            r_init_back <= 16'h0000;
            r_phase     <= PH_TEXT;
            r_pchars    <= '0;
            r_pfield    <= 2'd0;
            r_p1        <= 8'd0;
            r_p2        <= 8'd0;
            r_p1v       <= 1'b0;
            r_p2v       <= 1'b0;
            r_row       <= 5'd0;
            r_col       <= 5'd0;
            r_srow      <= 5'd0;
            r_scol      <= 5'd0;
            r_fore      <= 16'hFFFF;
            r_back      <= 16'h0000;
            r_wrap      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ROWS: r_max_rows  <= i_cfg_data[5:0];
                    REG_COLS: r_max_cols  <= i_cfg_data[5:0];
                    REG_FORE: r_init_fore <= i_cfg_data;
                    REG_BACK: r_init_back <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.step) begin
                if (r_phase == PH_SEQ) begin
                    if (is_digit || c == CH_SEMI) begin
                        if (r_pchars < PCW'(PARAM_BUFFER_LEN)) begin
                            r_pchars <= r_pchars + 1'b1;
                            if (c == CH_SEMI) begin
                                if (r_pfield < 2'd2) r_pfield <= r_pfield + 2'd1;
                            end else if (r_pfield == 2'd0) begin
                                r_p1  <= (mul_sat(r_p1, dval));
                                r_p1v <= 1'b1;
                            end else if (r_pfield == 2'd1) begin
                                r_p2  <= (mul_sat(r_p2, dval));
                                r_p2v <= 1'b1;
                            end
                        end
                    end else begin
                        r_phase  <= PH_TEXT;
                        r_pchars <= '0;
                        r_pfield <= 2'd0;
                        r_p1     <= 8'd0;
                        r_p2     <= 8'd0;
                        r_p1v    <= 1'b0;
                        r_p2v    <= 1'b0;
                        case (c)
                            "h": if (r_p1v && r_p1 == 8'd7) r_wrap <= 1'b1;
                            "l": if (r_p1v && r_p1 == 8'd7) r_wrap <= 1'b0;
                            "H", "f": begin
                                if (r_p1v && {2'b0, r_p1} < {4'b0, rows}) r_row <= r_p1[4:0];
                                if (r_p2v && {2'b0, r_p2} < {4'b0, cols}) r_col <= r_p2[4:0];
                                if (!r_p1v && !r_p2v) begin
                                    r_row <= 5'd0;
                                    r_col <= 5'd0;
                                end
                            end
                            "A": r_row <= cnt_gt(r_p1v, r_p1, r_row) ? 5'd0 : r_row - cnt[4:0];
                            "B": r_row <= (sum_r >= {1'b0, rows}) ? 5'(rows - 6'd1) : sum_r[4:0];
                            "C": r_col <= (sum_c >= {1'b0, cols}) ? 5'(cols - 6'd1) : sum_c[4:0];
                            "D": r_col <= cnt_gt(r_p1v, r_p1, r_col) ? 5'd0 : r_col - cnt[4:0];
                            "s": begin
                                r_srow <= r_row;
                                r_scol <= r_col;
                            end
                            "u": begin
                                r_row <= r_srow;
                                r_col <= r_scol;
                            end
                            "J": if (r_p1v && r_p1 == 8'd2) begin
                                r_row <= 5'd0;
                                r_col <= 5'd0;
                            end
                            "m": if (r_p1v && r_p1 >= 8'd30 && r_p1 <= 8'd47) begin
                                if (r_p1 <= 8'd37) r_fore <= palette(3'(r_p1 - 8'd30));
                                else if (r_p1 >= 8'd40) r_back <= palette(3'(r_p1 - 8'd40));
                                if (r_p2v && r_p2 >= 8'd30 && r_p2 <= 8'd47) begin
                                    if (r_p2 <= 8'd37) r_fore <= palette(3'(r_p2 - 8'd30));
                                    else if (r_p2 >= 8'd40)
                                        r_back <= palette(3'(r_p2 - 8'd40));
                                end
                            end
                            default: ;
                        endcase
                    end
                end else if (r_phase == PH_ESC) begin
                    r_phase  <= (c == CH_LBR) ? PH_SEQ : PH_TEXT;
                    r_pchars <= '0;
                    r_pfield <= 2'd0;
                    r_p1     <= 8'd0;
                    r_p2     <= 8'd0;
                    r_p1v    <= 1'b0;
                    r_p2v    <= 1'b0;
                end else if (c == CH_ESC) begin
                    r_phase <= PH_ESC;
                end else if (c == CH_CR) begin
                    r_col <= 5'd0;
                end else if (c == CH_LF) begin
                    r_row <= row_dn1[4:0];
                end else if (c == CH_BS) begin
                    if (r_col != 5'd0) r_col <= r_col - 5'd1;
                end else begin
                    if ({1'b0, r_col} + 6'd1 >= cols) begin
                        if (r_wrap) begin
                            r_col <= 5'd0;
                            r_row <= row_dn1[4:0];
                        end else begin
                            r_col <= 5'(cols - 6'd1);
                        end
                    end else begin
                        r_col <= r_col + 5'd1;
                    end
                end
            end
        end
    end

    logic unused_ok;
    assign unused_ok = ^{r_init_fore, r_init_back};
endmodule

@@ hw/rtl/vt100_escape_text_engine.sv @@
// ----------------------------------------------------------------------------
// VT100 escape text engine
// Turns a byte stream with escape sequences into cell draw and clear commands.
// ----------------------------------------------------------------------------
// The controller captures each byte, processes it and, when it makes results,
// emits them, erase-run cells one per cycle while the output is ready; no new
// byte is taken until the last result of the byte before has been transferred.
module vt100_escape_text_engine #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32,
    parameter int PARAM_BUFFER_LEN = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    vt100_stream_if.sink   s_in,
    vt100_stream_if.source m_out
);
    import vt100_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    t_result    res;

    vt100_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_in.valid),
        .o_in_ready  (s_in.ready),
        .o_out_valid (m_out.valid),
        .i_out_ready (m_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    vt100_dp #(
        .MAX_COLS         (MAX_COLS),
        .MAX_ROWS         (MAX_ROWS),
        .PARAM_BUFFER_LEN (PARAM_BUFFER_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_code (s_in.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (res)
    );

    assign m_out.data = res;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_in.ready && m_out.valid)) else $error("input taken during output");
    a_clear_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && m_out.data.command |-> m_out.data.last_of_run)
        else $error("clear not last");
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.valid && s_in.ready |=> !s_in.ready && !m_out.valid)
        else $error("no processing cycle");
endmodule
